// ===== src/lcdns_pkg.sv =====
package lcdns_pkg;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NLINE = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_DELAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_UP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_GAP  = 3'd3;

    localparam logic [16:0] SHORT_DELAY_RST = 17'd46;
    localparam logic [16:0] LONG_DELAY_RST  = 17'd1843;
    localparam logic [23:0] POWER_UP_RST    = 24'd921600;
    localparam logic [7:0]  NIBBLE_GAP_RST  = 8'd1;

    localparam logic [7:0] BYTE_CLEAR   = 8'h01;
    localparam logic [7:0] BYTE_NEWLINE = 8'hC0;

    // init command bytes in order: function set, display on, clear, entry mode
    localparam logic [7:0] INIT_BYTES [4] = '{8'h28, 8'h0F, 8'h01, 8'h06};
    localparam logic [1:0] INIT_CLEAR_SLOT = 2'd2;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd9;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [16:0] short_delay;
        logic [16:0] long_delay;
        logic [23:0] power_up_delay;
        logic [7:0]  nibble_gap;
    } cfg_t;

    // classified command as held in the queue
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] data;
        logic       tail_long;
    } desc_t;

endpackage

// ===== src/lcdns_if.sv =====
interface lcdns_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface lcdns_res_if;
    logic        valid;
    logic        ready;
    logic        strobe_res;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [23:0] delay_ticks;
    logic        backlight;
    logic        last;

    modport source (output valid, output strobe_res, output reg_select, output nibble,
                    output delay_ticks, output backlight, output last, input ready);
    modport sink (input valid, input strobe_res, input reg_select, input nibble,
                  input delay_ticks, input backlight, input last, output ready);
endinterface

// ===== src/lcdns_front.sv =====
module lcdns_front
(
    lcdns_cmd_if.sink         cmd_ch,
    output logic              push_valid,
    input  logic              push_ready,
    output lcdns_pkg::desc_t  push_data
);

    lcdns_pkg::cmd_t cmd_code;

    assign cmd_code = lcdns_pkg::cmd_t'(cmd_ch.cmd);
    assign push_valid = cmd_ch.valid;
    assign cmd_ch.ready = push_ready;

    always_comb
    begin
        push_data = '0;
        unique case (cmd_code)
            lcdns_pkg::CMD_INIT:
            begin
                push_data.is_init = 1'b1;
            end
            lcdns_pkg::CMD_CHAR:
            begin
                push_data.rs = 1'b1;
                push_data.data = cmd_ch.data_byte;
            end
            lcdns_pkg::CMD_CLEAR:
            begin
                push_data.data = lcdns_pkg::BYTE_CLEAR;
                push_data.tail_long = 1'b1;
            end
            lcdns_pkg::CMD_NLINE:
            begin
                push_data.data = lcdns_pkg::BYTE_NEWLINE;
                push_data.tail_long = 1'b1;
            end
            default:
            begin
                push_data = '0;
            end
        endcase
    end

endmodule

// ===== src/lcdns_fifo.sv =====
module lcdns_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  lcdns_pkg::desc_t  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output lcdns_pkg::desc_t  pop_data
);

    localparam int PTR_W = (lcdns_pkg::FIFO_DEPTH > 1) ? $clog2(lcdns_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(lcdns_pkg::FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(lcdns_pkg::FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(lcdns_pkg::FIFO_DEPTH - 1);

    lcdns_pkg::desc_t mem_reg [lcdns_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != DEPTH_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/lcdns_back.sv =====
module lcdns_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  lcdns_pkg::cfg_t   cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  lcdns_pkg::desc_t  pop_data,
    lcdns_res_if.source       res_ch
);

    lcdns_pkg::desc_t cur_reg;
    logic             busy_reg, busy_next;
    logic [lcdns_pkg::STEP_W-1:0] step_reg, step_next;
    logic             backlight_reg, backlight_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_strobe_reg, out_rs_reg, out_bl_reg, out_last_reg;
    logic [3:0]  out_nib_reg;
    logic [23:0] out_delay_reg;

    logic        emit, load;
    logic        it_strobe, it_rs, it_bl, it_last;
    logic [3:0]  it_nib;
    logic [23:0] it_delay;
    logic [23:0] short_ext, long_ext, clear_wait, gap_ext, lo_tail;
    logic [lcdns_pkg::STEP_W-1:0] step_m1;
    logic [7:0]  cur_byte;
    logic        lo_half;

    assign short_ext  = {7'd0, cfg.short_delay};
    assign long_ext   = {7'd0, cfg.long_delay};
    assign clear_wait = {6'd0, cfg.long_delay, 1'b0};
    assign gap_ext    = {16'd0, cfg.nibble_gap};

    assign emit = busy_reg && (!out_valid_reg || res_ch.ready);
    assign load = pop_valid && (!busy_reg || (emit && it_last));
    assign pop_ready = load;

    // build the item for the current step
    always_comb
    begin
        step_m1   = step_reg - 1'b1;
        it_strobe = 1'b1;
        it_rs     = cur_reg.rs;
        it_bl     = backlight_reg;
        it_last   = 1'b0;
        cur_byte  = cur_reg.data;
        lo_half   = step_reg[0];
        lo_tail   = cur_reg.tail_long ? clear_wait : short_ext;
        if (cur_reg.is_init)
        begin
            cur_byte = lcdns_pkg::INIT_BYTES[step_m1[2:1]];
            lo_half  = step_m1[0];
            lo_tail  = (step_m1[2:1] == lcdns_pkg::INIT_CLEAR_SLOT) ? clear_wait : short_ext;
        end
        it_nib   = lo_half ? cur_byte[3:0] : cur_byte[7:4];
        it_delay = lo_half ? lo_tail : gap_ext;
        if (cur_reg.is_init)
        begin
            if (step_reg == '0)
            begin
                it_strobe = 1'b0;
                it_nib    = '0;
                it_delay  = cfg.power_up_delay;
            end
            else if (step_reg == lcdns_pkg::INIT_LAST_STEP)
            begin
                it_strobe = 1'b0;
                it_nib    = '0;
                it_delay  = long_ext;
                it_bl     = 1'b1;
                it_last   = 1'b1;
            end
        end
        else
        begin
            it_last = (step_reg == lcdns_pkg::BYTE_LAST_STEP);
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        backlight_next = backlight_reg;
        out_valid_next = out_valid_reg;
        if (res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            backlight_next = it_bl;
            step_next      = step_reg + 1'b1;
            if (it_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            step_reg       <= '0;
            backlight_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_strobe_reg <= 1'b0;
            out_rs_reg     <= 1'b0;
            out_nib_reg    <= '0;
            out_delay_reg  <= '0;
            out_bl_reg     <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            backlight_reg <= backlight_next;
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                out_strobe_reg <= it_strobe;
                out_rs_reg     <= it_strobe & it_rs;
                out_nib_reg    <= it_nib;
                out_delay_reg  <= it_delay;
                out_bl_reg     <= it_bl;
                out_last_reg   <= it_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= pop_data;
        end
    end

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.strobe_res  = out_strobe_reg;
    assign res_ch.reg_select  = out_rs_reg;
    assign res_ch.nibble      = out_nib_reg;
    assign res_ch.delay_ticks = out_delay_reg;
    assign res_ch.backlight   = out_bl_reg;
    assign res_ch.last        = out_last_reg;

endmodule

// ===== src/char_lcd_nibble_sequencer.sv =====
// Character LCD sequencer for a 4-bit bus. Each command transfer expands into a run of
// result items, one item per clock while the result side is ready: init gives ten items
// (power-up wait, four command bytes as high/low strobes, final wait with backlight on), and
// write character, clear and new line give two strobes each. A two-entry command queue
// sits between the command decoder and the item generator, so a command is taken in any
// cycle the queue has room, and the item generator picks up the next command in the same
// cycle it issues the last item of the current one. Throughput is set by the item
// generator: one result per cycle while res_ch is ready; queued commands run without gaps.
// Configuration writes take effect on the next clock and should only be issued while idle.
module char_lcd_nibble_sequencer
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    lcdns_cmd_if.sink                              cmd_ch,
    lcdns_res_if.source                            res_ch,
    input  logic                                   cfg_we,
    input  logic [lcdns_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lcdns_pkg::CFG_DATA_W-1:0]       cfg_data
);

    lcdns_pkg::cfg_t  cfg_reg, cfg_next;
    logic             push_valid, push_ready, pop_valid, pop_ready;
    lcdns_pkg::desc_t push_data, pop_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                lcdns_pkg::REG_SHORT_DELAY: cfg_next.short_delay    = cfg_data[16:0];
                lcdns_pkg::REG_LONG_DELAY:  cfg_next.long_delay     = cfg_data[16:0];
                lcdns_pkg::REG_POWER_UP:    cfg_next.power_up_delay = cfg_data[23:0];
                lcdns_pkg::REG_NIBBLE_GAP:  cfg_next.nibble_gap     = cfg_data[7:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_delay    <= lcdns_pkg::SHORT_DELAY_RST;
            cfg_reg.long_delay     <= lcdns_pkg::LONG_DELAY_RST;
            cfg_reg.power_up_delay <= lcdns_pkg::POWER_UP_RST;
            cfg_reg.nibble_gap     <= lcdns_pkg::NIBBLE_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lcdns_front u_front
    (
        .cmd_ch     (cmd_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lcdns_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lcdns_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .res_ch    (res_ch)
    );

endmodule

// ===== src/lcdns_checker.sv =====
module lcdns_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        res_strobe,
    input logic        res_rs,
    input logic [3:0]  res_nibble,
    input logic        res_backlight,
    input logic        res_last
);

    // hold a result until it is transferred
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before transfer");

    // wait items carry no register select and no nibble
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_strobe |-> !res_rs && (res_nibble == 4'd0))
        else $error("wait item with nonzero bus fields");

    // a closing wait only ends init, which turns the backlight on
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_strobe && res_last |-> res_backlight)
        else $error("init finished without backlight");

    // backlight never goes off once on
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(res_backlight))
        else $error("backlight turned off");

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_ch.valid),
    .res_ready     (res_ch.ready),
    .res_strobe    (res_ch.strobe_res),
    .res_rs        (res_ch.reg_select),
    .res_nibble    (res_ch.nibble),
    .res_backlight (res_ch.backlight),
    .res_last      (res_ch.last)
);

// ===== test/lcd_sequence_checker.sv =====
`timescale 1ns / 100ps

module lcd_sequence_checker
    import lcdns_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    lcdns_cmd_if                 cmd_mon,
    lcdns_res_if                 res_mon,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   cmds_seen,
    output int                   inits_seen,
    output int                   items_checked
);

    localparam logic [7:0] FUNCTION_SET = 8'h28;
    localparam logic [7:0] DISPLAY_ON   = 8'h0F;
    localparam logic [7:0] ENTRY_MODE   = 8'h06;

    typedef struct packed {
        logic        strobe_res;
        logic        reg_select;
        logic [3:0]  nibble;
        logic [23:0] delay_ticks;
        logic        backlight;
        logic        last;
    } lcd_item_t;

    lcd_item_t   lcd_items_due[$];

    logic [16:0] short_dly;
    logic [16:0] long_dly;
    logic [23:0] power_up_dly;
    logic [7:0]  gap_dly;
    logic        backlight_on;

    function automatic lcd_item_t make_item(input logic strobe, input logic rs,
                                            input logic [3:0] nib, input logic [23:0] dly,
                                            input logic is_last);
        lcd_item_t it;
        it.strobe_res  = strobe;
        it.reg_select  = rs;
        it.nibble      = nib;
        it.delay_ticks = dly;
        it.backlight   = backlight_on;
        it.last        = is_last;
        return it;
    endfunction

    // high nibble first, gap after it; the low strobe carries the tail delay
    task automatic push_byte(input logic rs, input logic [7:0] val, input logic [23:0] tail,
                             input logic is_last);
        lcd_items_due.push_back(make_item(1'b1, rs, val[7:4], {16'd0, gap_dly}, 1'b0));
        lcd_items_due.push_back(make_item(1'b1, rs, val[3:0], tail, is_last));
    endtask

    task automatic expand_command(input cmd_t op, input logic [7:0] char_code);
        logic [23:0] short_wait;
        logic [23:0] clear_wait;
        short_wait = {7'd0, short_dly};
        clear_wait = {6'd0, long_dly, 1'b0};
        case (op)
            CMD_INIT:
            begin
                lcd_items_due.push_back(make_item(1'b0, 1'b0, 4'd0, power_up_dly, 1'b0));
                push_byte(1'b0, FUNCTION_SET, short_wait, 1'b0);
                push_byte(1'b0, DISPLAY_ON, short_wait, 1'b0);
                push_byte(1'b0, BYTE_CLEAR, clear_wait, 1'b0);
                push_byte(1'b0, ENTRY_MODE, short_wait, 1'b0);
                // backlight turns on with the closing wait
                backlight_on = 1'b1;
                lcd_items_due.push_back(make_item(1'b0, 1'b0, 4'd0, {7'd0, long_dly}, 1'b1));
            end
            CMD_CHAR:  push_byte(1'b1, char_code, short_wait, 1'b1);
            CMD_CLEAR: push_byte(1'b0, BYTE_CLEAR, clear_wait, 1'b1);
            default:   push_byte(1'b0, BYTE_NEWLINE, clear_wait, 1'b1);
        endcase
    endtask

    task automatic compare_item();
        lcd_item_t got;
        lcd_item_t want;
        got.strobe_res  = res_mon.strobe_res;
        got.reg_select  = res_mon.reg_select;
        got.nibble      = res_mon.nibble;
        got.delay_ticks = res_mon.delay_ticks;
        got.backlight   = res_mon.backlight;
        got.last        = res_mon.last;
        items_checked++;
        if (lcd_items_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%t: unexpected item strobe=%0b rs=%0b nib=%h dly=%0d bl=%0b last=%0b",
                         $realtime, got.strobe_res, got.reg_select, got.nibble,
                         got.delay_ticks, got.backlight, got.last);
        end
        else
        begin
            want = lcd_items_due.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%t: item mismatch", $realtime);
                    $display("    exp strobe=%0b rs=%0b nib=%h dly=%0d bl=%0b last=%0b",
                             want.strobe_res, want.reg_select, want.nibble,
                             want.delay_ticks, want.backlight, want.last);
                    $display("    got strobe=%0b rs=%0b nib=%h dly=%0d bl=%0b last=%0b",
                             got.strobe_res, got.reg_select, got.nibble,
                             got.delay_ticks, got.backlight, got.last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_dly     = SHORT_DELAY_RST;
            long_dly      = LONG_DELAY_RST;
            power_up_dly  = POWER_UP_RST;
            gap_dly       = NIBBLE_GAP_RST;
            backlight_on  = 1'b0;
            lcd_items_due.delete();
            mismatches    = 0;
            cmds_seen     = 0;
            inits_seen    = 0;
            items_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SHORT_DELAY: short_dly    = cfg_data[16:0];
                    REG_LONG_DELAY:  long_dly     = cfg_data[16:0];
                    REG_POWER_UP:    power_up_dly = cfg_data[23:0];
                    REG_NIBBLE_GAP:  gap_dly      = cfg_data[7:0];
                    default: ;
                endcase
            end
            // queue new expectations first so a same-cycle result still finds them
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                cmds_seen++;
                if (cmd_t'(cmd_mon.cmd) == CMD_INIT)
                    inits_seen++;
                expand_command(cmd_t'(cmd_mon.cmd), cmd_mon.data_byte);
            end
            if (res_mon.valid && res_mon.ready)
                compare_item();
        end
        outstanding = lcd_items_due.size();
    end

endmodule

// ===== test/tb_char_lcd_nibble_sequencer.sv =====
`timescale 1ns / 100ps

module tb_char_lcd_nibble_sequencer;
    import lcdns_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;
    localparam int RANDOM_PER_SETTING = 50;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic quiet;

    int mismatches;
    int outstanding;
    int cmds_seen;
    int inits_seen;
    int items_checked;
    int settings_used;
    int ready_left;

    lcdns_cmd_if cmd_ch();
    lcdns_res_if res_ch();

    char_lcd_nibble_sequencer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .res_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lcd_sequence_checker u_seq_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_mon       (cmd_ch),
        .res_mon       (res_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .cmds_seen     (cmds_seen),
        .inits_seen    (inits_seen),
        .items_checked (items_checked)
    );

    always #5 clk = ~clk;

    // result side: alternate random ready stretches with stall bursts
    always @(negedge clk)
    begin
        if (quiet)
            res_ch.ready <= 1'b1;
        else if (ready_left > 0)
            ready_left--;
        else if ($urandom_range(0, 2) == 0)
        begin
            res_ch.ready <= 1'b0;
            ready_left = $urandom_range(0, 12);
        end
        else
        begin
            res_ch.ready <= 1'b1;
            ready_left = $urandom_range(0, 29);
        end
    end

    task automatic send_cmd(input cmd_t op, input logic [7:0] char_code);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.cmd       <= op;
        cmd_ch.data_byte <= char_code;
        do @(posedge clk); while (!cmd_ch.ready);
    endtask

    // drop valid, then hold until every expected item has come back
    task automatic wait_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] short_val,
                             input logic [CFG_DATA_W-1:0] long_val,
                             input logic [CFG_DATA_W-1:0] power_val,
                             input logic [CFG_DATA_W-1:0] gap_val);
        write_reg(REG_SHORT_DELAY, short_val);
        write_reg(REG_LONG_DELAY, long_val);
        write_reg(REG_POWER_UP, power_val);
        write_reg(REG_NIBBLE_GAP, gap_val);
        // writes past the last register must leave everything alone
        write_reg(CFG_IDX_W'(REG_UNUSED_FIRST
                  + $urandom_range(0, REG_UNUSED_LAST - REG_UNUSED_FIRST)),
                  CFG_DATA_W'($urandom()));
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_cmds(input int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 3)
                send_cmd(CMD_INIT, 8'($urandom()));
            else if (pick < 12)
                send_cmd(CMD_CHAR, 8'($urandom()));
            else if (pick < 16)
                send_cmd(CMD_CLEAR, 8'($urandom()));
            else
                send_cmd(CMD_NLINE, 8'($urandom()));
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.cmd       = CMD_INIT;
        cmd_ch.data_byte = 8'd0;
        res_ch.ready     = 1'b0;
        quiet            = 1'b0;
        ready_left       = 0;
        settings_used    = 1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: commands before init see the backlight off
        send_cmd(CMD_CHAR, 8'h41);
        send_cmd(CMD_CLEAR, 8'hFF);
        send_cmd(CMD_NLINE, 8'h00);
        send_cmd(CMD_INIT, 8'h00);
        send_cmd(CMD_CHAR, 8'h00);
        send_cmd(CMD_CHAR, 8'hFF);
        send_cmd(CMD_CHAR, 8'hA5);
        send_cmd(CMD_CHAR, 8'h5A);
        send_cmd(CMD_CLEAR, 8'h00);
        send_cmd(CMD_NLINE, 8'hFF);
        send_cmd(CMD_INIT, 8'hFF);
        send_cmd(CMD_CHAR, 8'($urandom()));
        wait_drained();

        // all delays zero
        configure(24'd0, 24'd0, 24'd0, 24'd0);
        send_cmd(CMD_INIT, 8'h00);
        send_cmd(CMD_CHAR, 8'h7E);
        send_cmd(CMD_CLEAR, 8'h00);
        send_cmd(CMD_NLINE, 8'h00);
        random_cmds(RANDOM_PER_SETTING);
        wait_drained();

        // every data bit set; narrower registers get truncated
        configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_cmd(CMD_INIT, 8'hFF);
        send_cmd(CMD_CLEAR, 8'hFF);
        send_cmd(CMD_NLINE, 8'hFF);
        random_cmds(RANDOM_PER_SETTING);
        wait_drained();

        configure(24'd1, 24'd1, 24'd1, 24'd0);
        random_cmds(RANDOM_PER_SETTING);
        wait_drained();

        configure(24'd65536, 24'd65536, 24'd16777215, 24'd255);
        random_cmds(RANDOM_PER_SETTING);
        wait_drained();

        configure(24'($urandom_range(1, 65536)), 24'($urandom_range(1, 65536)),
                  24'($urandom_range(1, 16777215)), 24'($urandom_range(0, 255)));
        random_cmds(RANDOM_PER_SETTING);
        wait_drained();

        // back to power-on values, both sides streaming with no idling
        configure(24'(SHORT_DELAY_RST), 24'(LONG_DELAY_RST), 24'(POWER_UP_RST),
                  24'(NIBBLE_GAP_RST));
        quiet = 1'b1;
        random_cmds(RANDOM_PER_SETTING);
        wait_drained();
        repeat (20) @(negedge clk);

        $display("Sent %0d commands (%0d init) over %0d register settings,",
                 cmds_seen, inits_seen, settings_used);
        $display("zero, full-width and in-range extremes included; %0d items compared.",
                 items_checked);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches, %0d items never arrived", mismatches, outstanding);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d items outstanding", outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== char_lcd_nibble_sequencer.f =====
src/lcdns_pkg.sv
src/lcdns_if.sv
src/lcdns_front.sv
src/lcdns_fifo.sv
src/lcdns_back.sv
src/char_lcd_nibble_sequencer.sv
src/lcdns_checker.sv
test/lcd_sequence_checker.sv
test/tb_char_lcd_nibble_sequencer.sv
